>>> src/serial_line_editor_unit_macros.svh
// ============================================================================
// Serial line editor assertion macros
// Shared concurrent assertion forms used by the line editor RTL.
// ============================================================================
`ifndef SERIAL_LINE_EDITOR_UNIT_MACROS_SVH
`define SERIAL_LINE_EDITOR_UNIT_MACROS_SVH

// The condition must hold at every clock edge outside reset.
`define SLE_ASSERT_ALWAYS(label, clk, rst_n, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error("sle assertion failed");

// When the antecedent holds, the consequent must hold in the same cycle.
`define SLE_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("sle assertion failed");

// When the antecedent holds, the consequent must hold in the next cycle.
`define SLE_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("sle assertion failed");

`endif

>>> src/sle_pkg.sv
// ============================================================================
// Serial line editor package
// Types, character codes and sizing constants shared by the editor modules.
// ============================================================================
package sle_pkg;

    localparam int SLE_LINE_DEPTH  = 64;
    localparam int SLE_QUEUE_DEPTH = 4;

    localparam logic [7:0] CH_BS    = 8'd8;
    localparam logic [7:0] CH_LF    = 8'd10;
    localparam logic [7:0] CH_CR    = 8'd13;
    localparam logic [7:0] CH_SPACE = 8'd32;

    localparam logic KIND_ECHO = 1'b0;
    localparam logic KIND_LINE = 1'b1;

    typedef enum logic [1:0] {
        OP_APPEND = 2'd0,
        OP_TERM   = 2'd1,
        OP_BS     = 2'd2
    } t_op;

    // One classified input word waiting for the back end.
    typedef struct packed {
        t_op        op;
        logic [7:0] data;
    } t_cmd;

    // One result word on the output stream.
    typedef struct packed {
        logic       kind;
        logic [7:0] data;
        logic       last;
    } t_out;

    // Queue status as seen by the back end.
    typedef struct packed {
        logic valid;
        t_cmd cmd;
    } t_q_head;

endpackage

>>> src/sle_ram.sv
// ============================================================================
// Generic RAM
// Simple dual-port memory: one write port, one read port with registered data.
// ============================================================================
module sle_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

>>> src/sle_front.sv
// ============================================================================
// Serial line editor front end
// Accepts received words and classifies them into editing commands.
// ============================================================================
module sle_front import sle_pkg::*; (
    input  logic       i_s_tvalid,
    output logic       o_s_tready,
    input  logic [7:0] i_s_tdata,
    input  logic       i_q_full,
    output logic       o_push,
    output t_cmd       o_cmd
);

    t_op op;

    always_comb begin
        if (i_s_tdata inside {CH_CR, CH_LF}) begin
            op = OP_TERM;
        end else if (i_s_tdata == CH_BS) begin
            op = OP_BS;
        end else begin
            op = OP_APPEND;
        end
    end

    assign o_s_tready = !i_q_full;
    assign o_push     = i_s_tvalid && !i_q_full;
    assign o_cmd      = '{op: op, data: i_s_tdata};

endmodule

>>> src/sle_queue.sv
// ============================================================================
// Serial line editor command queue
// Short FIFO of classified commands between the front and back ends.
// ============================================================================
module sle_queue import sle_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_push,
    input  t_cmd    i_cmd,
    output logic    o_full,
    input  logic    i_pop,
    output t_q_head o_head
);

    localparam int PTR_W = (SLE_QUEUE_DEPTH > 1) ? $clog2(SLE_QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(SLE_QUEUE_DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(SLE_QUEUE_DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(SLE_QUEUE_DEPTH);

    t_cmd             r_slot [SLE_QUEUE_DEPTH];
    logic [PTR_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic             do_push, do_pop;

    assign o_full  = (r_cnt == CNT_FULL);
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && (r_cnt != '0);

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_cnt    = r_cnt;
        if (do_push) begin
            n_wr_ptr = (r_wr_ptr == PTR_LAST) ? '0 : r_wr_ptr + PTR_W'(1);
        end
        if (do_pop) begin
            n_rd_ptr = (r_rd_ptr == PTR_LAST) ? '0 : r_rd_ptr + PTR_W'(1);
        end
        if (do_push && !do_pop) begin
            n_cnt = r_cnt + CNT_W'(1);
        end else if (do_pop && !do_push) begin
            n_cnt = r_cnt - CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_cnt    <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_cnt    <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_slot[r_wr_ptr] <= i_cmd;
        end
    end

    assign o_head = '{valid: (r_cnt != '0), cmd: r_slot[r_rd_ptr]};

endmodule

>>> src/sle_back.sv
// ============================================================================
// Serial line editor back end
// Executes editing commands on the line store and drives the result stream.
// ============================================================================
`include "serial_line_editor_unit_macros.svh"

module sle_back import sle_pkg::*; #(
    parameter int LINE_DEPTH = SLE_LINE_DEPTH
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_q_head    i_head,
    output logic       o_pop,
    output logic       o_m_tvalid,
    input  logic       i_m_tready,
    output t_out       o_m_word
);

    localparam int ADDR_W = $clog2(LINE_DEPTH);
    localparam int CNT_W  = $clog2(LINE_DEPTH + 1);
    localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(LINE_DEPTH);

    typedef enum logic [3:0] {
        ST_IDLE    = 4'b0001,
        ST_ECHO    = 4'b0010,
        ST_LINE_RD = 4'b0100,
        ST_LINE_WR = 4'b1000
    } t_state;

    t_state            r_state, n_state;
    logic [CNT_W-1:0]  r_count, n_count;
    logic [ADDR_W-1:0] r_idx, n_idx;
    logic [1:0]        r_echo_step, n_echo_step;
    logic              r_out_valid, n_out_valid;
    t_out              r_out, n_out;

    logic              out_free;
    logic              line_last;
    logic              wr_en, rd_en;
    logic [7:0]        rd_data;

    assign out_free  = !r_out_valid || i_m_tready;
    assign line_last = ((CNT_W'(r_idx) + CNT_W'(1)) == r_count);
    assign o_pop     = (r_state == ST_IDLE) && i_head.valid;
    assign wr_en     = o_pop && (i_head.cmd.op == OP_APPEND) && (r_count < CNT_MAX);
    assign rd_en     = (r_state == ST_LINE_RD);

    sle_ram #(
        .WIDTH (8),
        .DEPTH (LINE_DEPTH)
    ) u_line_store (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (r_count[ADDR_W-1:0]),
        .i_wr_data (i_head.cmd.data),
        .i_rd_en   (rd_en),
        .i_rd_addr (r_idx),
        .o_rd_data (rd_data)
    );

    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_idx       = r_idx;
        n_echo_step = r_echo_step;
        n_out       = r_out;
        n_out_valid = r_out_valid && !i_m_tready;

        case (r_state)
            ST_IDLE: begin
                if (o_pop) begin
                    case (i_head.cmd.op)
                        OP_APPEND: begin
                            if (r_count < CNT_MAX) begin
                                n_count = r_count + CNT_W'(1);
                            end
                        end
                        OP_BS: begin
                            if (r_count != '0) begin
                                n_count     = r_count - CNT_W'(1);
                                n_echo_step = '0;
                                n_state     = ST_ECHO;
                            end
                        end
                        OP_TERM: begin
                            if (r_count != '0) begin
                                n_idx   = '0;
                                n_state = ST_LINE_RD;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            ST_ECHO: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_out.kind  = KIND_ECHO;
                    n_out.data  = (r_echo_step == 2'd1) ? CH_SPACE : CH_BS;
                    n_out.last  = (r_echo_step == 2'd2);
                    if (r_echo_step == 2'd2) begin
                        n_state = ST_IDLE;
                    end else begin
                        n_echo_step = r_echo_step + 2'd1;
                    end
                end
            end
            ST_LINE_RD: begin
                n_state = ST_LINE_WR;
            end
            ST_LINE_WR: begin
                // The read data stays put here since no new read is issued.
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_out.kind  = KIND_LINE;
                    n_out.data  = rd_data;
                    n_out.last  = line_last;
                    if (line_last) begin
                        n_count = '0;
                        n_state = ST_IDLE;
                    end else begin
                        n_idx   = r_idx + ADDR_W'(1);
                        n_state = ST_LINE_RD;
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_count     <= '0;
            r_idx       <= '0;
            r_echo_step <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_idx       <= n_idx;
            r_echo_step <= n_echo_step;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out <= n_out;
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_word   = r_out;

    `SLE_ASSERT_ALWAYS(a_count_bound, i_clk, i_rst_n, r_count <= CNT_MAX)
    `SLE_ASSERT_IMPLY(a_line_nonempty, i_clk, i_rst_n,
        (r_state == ST_LINE_RD) || (r_state == ST_LINE_WR), r_count != '0)
    `SLE_ASSERT_NEXT(a_bs_echo, i_clk, i_rst_n,
        o_pop && (i_head.cmd.op == OP_BS) && (r_count != '0), r_state == ST_ECHO)
    `SLE_ASSERT_NEXT(a_line_done, i_clk, i_rst_n,
        (r_state == ST_LINE_WR) && out_free && line_last,
        (r_count == '0) && r_out_valid && r_out.last)

endmodule

>>> src/serial_line_editor_unit.sv
// ============================================================================
// Serial line editor
// Assembles command lines from received bytes with backspace editing.
// ============================================================================
// Received words are taken in one per cycle while the four-entry command
// queue has room. A stalled output holds the input back only after the back
// end has stopped on it and the queue has filled up. The back end drains the
// queue: an ordinary byte, a dropped byte or a terminator or backspace on an
// empty line is handled in the idle state alone; a backspace passes through
// the echo state and emits the three echo words; a terminator on a line of
// N bytes emits the N line words, each via a read state and a write state
// because of the registered line store RAM read. Output stalls hold the echo
// and write states. The line store needs no clearing pass after reset.
module serial_line_editor_unit import sle_pkg::*; #(
    parameter int LINE_DEPTH = SLE_LINE_DEPTH
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_s_axis_tvalid,
    output logic       o_s_axis_tready,
    input  logic [7:0] i_s_axis_tdata,  // [7:0] rx_byte
    output logic       o_m_axis_tvalid,
    input  logic       i_m_axis_tready,
    output logic [7:0] o_m_axis_tdata,  // [7:0] out_byte
    output logic       o_m_axis_tuser,  // [0] out_kind
    output logic       o_m_axis_tlast
);

    logic    push, pop, q_full;
    t_cmd    cmd;
    t_q_head head;
    t_out    word;

    sle_front u_front (
        .i_s_tvalid (i_s_axis_tvalid),
        .o_s_tready (o_s_axis_tready),
        .i_s_tdata  (i_s_axis_tdata),
        .i_q_full   (q_full),
        .o_push     (push),
        .o_cmd      (cmd)
    );

    sle_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (cmd),
        .o_full  (q_full),
        .i_pop   (pop),
        .o_head  (head)
    );

    sle_back #(
        .LINE_DEPTH (LINE_DEPTH)
    ) u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_head     (head),
        .o_pop      (pop),
        .o_m_tvalid (o_m_axis_tvalid),
        .i_m_tready (i_m_axis_tready),
        .o_m_word   (word)
    );

    assign o_m_axis_tdata = word.data;
    assign o_m_axis_tuser = word.kind;
    assign o_m_axis_tlast = word.last;

endmodule
